/* hw/rtl/lspi_pkg.sv */
// Shared types and constants of the line segment / plane intersection block.
`default_nettype none

package lspi_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned TolW      = 31;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned InW       = 9 * CoordW;
  localparam int unsigned OutBits   = 3 + 7 * CoordW;
  localparam int unsigned OutW      = 232;
  localparam int unsigned TCapLog   = 48;
  localparam int unsigned SqrtSteps = 32;

  localparam logic [TolW-1:0]   TolReset   = TolW'(66);
  localparam logic [TolW-1:0]   PtolReset  = TolW'(1);
  localparam logic [2*TolW-1:0] TolSqReset = (2*TolW)'(66 * 66);

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_START      = 3'd1,
    KIND_INTERIOR   = 3'd2,
    KIND_END        = 3'd3,
    KIND_COINCIDENT = 3'd4,
    KIND_DEGENERATE = 3'd5
  } hit_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5,
    REG_DIST_TOL = 3'd6,
    REG_PAR_TOL  = 3'd7
  } cfg_reg_e;

  // segment as it sits on the input word: start lowest, end highest
  typedef struct packed {
    logic [3*CoordW-1:0] p;
    logic [3*CoordW-1:0] e;
    logic [3*CoordW-1:0] d;
  } pay_t;

endpackage

`default_nettype wire

/* hw/rtl/line_segment_plane_intersect.sv */
// Top level: pipelined segment against plane classifier.
//
// Usage: write the plane (origin, normal) and the two tolerances through the
// cfg port while the block is idle; registers 0..7 in index order, reset gives
// origin 0, normal (0,0,1.0), distance tolerance 66, parallel tolerance 1.
// Segments enter on s_axis as one word each (start, direction, end); one
// result word per segment leaves on m_axis in the same order.
// Throughput: one word per cycle while s_axis_tready is high. From acceptance to
// m_axis_tvalid a word passes four front stages (dot products, sums, magnitudes,
// compares) and an entry stage, one stage per quotient bit of t (48 bits)
// running alongside the 32-stage square root of |E|^2 and the FRAC_BITS + 1
// stage divider of the relative tolerance, then five stages of sign, thresholds,
// compare, interior multiply and output. Each stage holds one restoring step,
// so the step count sets the depth.
// Reset clears the valid bits and loads the configuration reset values.
// When m_axis stalls, the output register holds its word and one more word
// lands in a skid register; only then does s_axis_tready drop and the whole
// pipeline freeze, so nothing is lost or repeated.
`default_nettype none

module line_segment_plane_intersect import lspi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // start_x, start_y, start_z, dir_x, dir_y, dir_z, end_x, end_y, end_z
  input  logic [InW-1:0]     s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // hit_kind, line_param, hit_x, hit_y, hit_z, second_x, second_y, second_z, zero pad
  output logic [OutW-1:0]    m_axis_tdata
);

  localparam int unsigned NW       = 67 - FRAC_BITS;
  localparam int unsigned DivSteps = TCapLog;
  localparam int unsigned TrSteps  = FRAC_BITS + 1;
  localparam int unsigned TrEnd    = SqrtSteps + TrSteps;
  localparam int unsigned LD       = (DivSteps > TrEnd) ? DivSteps : TrEnd;
  localparam int unsigned TW       = TCapLog + 2;
  localparam int unsigned PW       = FRAC_BITS + CoordW + 2;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam logic signed [TW-1:0] OneT = TW'(64'd1 << FRAC_BITS);
  localparam logic [TW-1:0]        CapT = TW'(64'd1 << TCapLog);

  typedef struct packed {
    logic nonpar;
    logic err;
    logic on;
  } flags_t;

  typedef struct packed {
    flags_t              fl;
    logic                neg;
    logic                ovf;
    logic [NW-1:0]       b;
    logic [NW-1:0]       dr;
    logic [DivSteps-1:0] nl;
    logic [DivSteps-1:0] q;
    logic [63:0]         s;
    logic [33:0]         sr;
    logic [31:0]         root;
    logic [32:0]         trr;
    logic [FRAC_BITS:0]  trn;
    logic [FRAC_BITS:0]  trq;
    pay_t                pay;
  } it_t;

  function automatic coord_t sat32(input logic signed [63:0] v);
    coord_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  // configuration
  coord_t            org_q [3];
  coord_t            nrm_q [3];
  logic [TolW-1:0]   tol_q, ptol_q;
  logic [2*TolW-1:0] tolsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= coord_t'(64'd1 << FRAC_BITS);
      tol_q    <= TolReset;
      ptol_q   <= PtolReset;
      tolsq_q  <= TolSqReset;
    end else begin
      tolsq_q <= tol_q * tol_q;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_ORIGIN_X: org_q[0] <= cfg_wdata_i;
          REG_ORIGIN_Y: org_q[1] <= cfg_wdata_i;
          REG_ORIGIN_Z: org_q[2] <= cfg_wdata_i;
          REG_NORMAL_X: nrm_q[0] <= cfg_wdata_i;
          REG_NORMAL_Y: nrm_q[1] <= cfg_wdata_i;
          REG_NORMAL_Z: nrm_q[2] <= cfg_wdata_i;
          REG_DIST_TOL: tol_q    <= cfg_wdata_i[TolW-1:0];
          REG_PAR_TOL:  ptol_q   <= cfg_wdata_i[TolW-1:0];
          default: ;
        endcase
      end
    end
  end

  // handshake and valid bits
  logic            en;
  logic            ov_q, sk_v_q;
  logic [3:0]      fv_q;
  logic [LD:0]     itv_q;
  logic [3:0]      pv_q;
  logic [OutW-1:0] out_q, sk_q, res;
  logic            pop;

  assign en            = !sk_v_q;
  assign s_axis_tready = en;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;
  assign pop           = ov_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q   <= '0;
      itv_q  <= '0;
      pv_q   <= '0;
      ov_q   <= 1'b0;
      sk_v_q <= 1'b0;
    end else begin
      if (en) begin
        fv_q  <= {fv_q[2:0], s_axis_tvalid};
        itv_q <= {itv_q[LD-1:0], fv_q[3]};
        pv_q  <= {pv_q[2:0], itv_q[LD]};
      end
      if (sk_v_q) begin
        if (pop) begin
          sk_v_q <= 1'b0;
        end
      end else if (ov_q && !pop) begin
        if (pv_q[3]) begin
          sk_v_q <= 1'b1;
        end
      end else begin
        ov_q <= pv_q[3];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (pop) begin
        out_q <= sk_q;
      end
    end else if (ov_q && !pop) begin
      sk_q <= res;
    end else begin
      out_q <= res;
    end
  end

  // front stages: products, sums, magnitudes, compares
  pay_t                     in_pay;
  pay_t                     pay_q [4];
  logic signed [ProdW-1:0]  pa_q [3];
  logic signed [ProdW-1:0]  pd_q [3];
  logic signed [ProdW-1:0]  pe_q [3];
  logic signed [ProdW-1:0]  ee_q [3];
  logic signed [CoordW:0]   df_q [3];
  logic signed [NW-1:0]     num2_q, den2_q, num2_d, den2_d;
  logic [63:0]              s2_q, s3_q, s4_q, s2_d;
  logic [CoordW:0]          m2_q [3];
  logic [CoordW:0]          m2_d [3];
  logic [2:0]               sm2_q, sm3_q, sm4_q;
  logic [NW-1:0]            a3_q, b3_q, a4_q, b4_q;
  logic                     neg3_q, neg4_q;
  logic [2*TolW-1:0]        sq3_q [3];
  logic                     nonpar4_q, err4_q, nsm4_q;
  logic [63:0]              sqs4_q;

  assign in_pay = pay_t'(s_axis_tdata);

  always_comb begin
    logic signed [NW-1:0] sa, sd, se;
    sa   = '0;
    sd   = '0;
    se   = '0;
    s2_d = '0;
    for (int i = 0; i < 3; i++) begin
      sa      = sa + NW'(pa_q[i] >>> FRAC_BITS);
      sd      = sd + NW'(pd_q[i] >>> FRAC_BITS);
      se      = se + NW'(pe_q[i] >>> FRAC_BITS);
      s2_d    = s2_d + $unsigned(ee_q[i]);
      m2_d[i] = df_q[i][CoordW] ? $unsigned(-df_q[i]) : $unsigned(df_q[i]);
    end
    num2_d = sa - sd;
    den2_d = se;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay_q[0] <= in_pay;
      for (int i = 0; i < 3; i++) begin
        pa_q[i] <= nrm_q[i] * org_q[i];
        pd_q[i] <= nrm_q[i] * $signed(in_pay.d[CoordW*i +: CoordW]);
        pe_q[i] <= nrm_q[i] * $signed(in_pay.e[CoordW*i +: CoordW]);
        ee_q[i] <= $signed(in_pay.e[CoordW*i +: CoordW]) *
                   $signed(in_pay.e[CoordW*i +: CoordW]);
        df_q[i] <= (CoordW+1)'($signed(in_pay.d[CoordW*i +: CoordW])) -
                   (CoordW+1)'(org_q[i]);
      end
      // sums
      pay_q[1] <= pay_q[0];
      num2_q   <= num2_d;
      den2_q   <= den2_d;
      s2_q     <= s2_d;
      for (int i = 0; i < 3; i++) begin
        m2_q[i]  <= m2_d[i];
        sm2_q[i] <= m2_d[i] < (CoordW+1)'(tol_q);
      end
      // magnitudes and squares
      pay_q[2] <= pay_q[1];
      a3_q     <= num2_q[NW-1] ? $unsigned(-num2_q) : $unsigned(num2_q);
      b3_q     <= den2_q[NW-1] ? $unsigned(-den2_q) : $unsigned(den2_q);
      neg3_q   <= num2_q[NW-1] ^ den2_q[NW-1];
      s3_q     <= s2_q;
      sm3_q    <= sm2_q;
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= m2_q[i][TolW-1:0] * m2_q[i][TolW-1:0];
      end
      // compares
      pay_q[3]  <= pay_q[2];
      a4_q      <= a3_q;
      b4_q      <= b3_q;
      neg4_q    <= neg3_q;
      s4_q      <= s3_q;
      sm4_q     <= sm3_q;
      nonpar4_q <= b3_q > NW'(ptol_q);
      err4_q    <= s3_q < 64'(tolsq_q);
      nsm4_q    <= a3_q < NW'(tol_q);
      sqs4_q    <= 64'(sq3_q[0]) + 64'(sq3_q[1]) + 64'(sq3_q[2]);
    end
  end

  // iterative section: quotient of t, square root of |E|^2, relative tolerance
  it_t it_q [LD+1];
  it_t it_d [LD+1];

  always_comb begin
    it_d[0]           = '0;
    it_d[0].fl.nonpar = nonpar4_q;
    it_d[0].fl.err    = err4_q;
    it_d[0].fl.on     = nsm4_q || ((&sm4_q) && (sqs4_q < 64'(tolsq_q)));
    it_d[0].neg       = neg4_q;
    it_d[0].b         = b4_q;
    it_d[0].dr        = a4_q >> (TCapLog - FRAC_BITS);
    it_d[0].ovf       = (a4_q >> (TCapLog - FRAC_BITS)) >= b4_q;
    it_d[0].nl        = DivSteps'(a4_q) << FRAC_BITS;
    it_d[0].s         = s4_q;
    it_d[0].trr       = 33'(tol_q >> 1);
    it_d[0].trn       = (FRAC_BITS+1)'(tol_q[0]) << FRAC_BITS;
    it_d[0].pay       = pay_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it_q[0] <= it_d[0];
    end
  end

  for (genvar k = 1; k <= LD; k++) begin : g_it
    localparam int unsigned J = k - 1;
    logic [NW:0]   dv;
    logic [33:0]   sqi, sqt;
    logic [32:0]   tdv;

    always_comb begin
      it_d[k] = it_q[k-1];
      dv      = {it_q[k-1].dr, it_q[k-1].nl[DivSteps-1]};
      sqi     = {it_q[k-1].sr[31:0], it_q[k-1].s[63:62]};
      sqt     = {it_q[k-1].root, 2'b01};
      tdv     = {it_q[k-1].trr[31:0], it_q[k-1].trn[FRAC_BITS]};
      if (J < DivSteps) begin
        it_d[k].nl = it_q[k-1].nl << 1;
        if (dv >= {1'b0, it_q[k-1].b}) begin
          it_d[k].dr = NW'(dv - {1'b0, it_q[k-1].b});
          it_d[k].q  = {it_q[k-1].q[DivSteps-2:0], 1'b1};
        end else begin
          it_d[k].dr = NW'(dv);
          it_d[k].q  = {it_q[k-1].q[DivSteps-2:0], 1'b0};
        end
      end
      if (J < SqrtSteps) begin
        it_d[k].s = it_q[k-1].s << 2;
        if (sqi >= sqt) begin
          it_d[k].sr   = sqi - sqt;
          it_d[k].root = {it_q[k-1].root[30:0], 1'b1};
        end else begin
          it_d[k].sr   = sqi;
          it_d[k].root = {it_q[k-1].root[30:0], 1'b0};
        end
      end
      if (J >= SqrtSteps && J < TrEnd) begin
        it_d[k].trn = it_q[k-1].trn << 1;
        if (tdv >= {1'b0, it_q[k-1].root}) begin
          it_d[k].trr = tdv - {1'b0, it_q[k-1].root};
          it_d[k].trq = {it_q[k-1].trq[FRAC_BITS-1:0], 1'b1};
        end else begin
          it_d[k].trr = tdv;
          it_d[k].trq = {it_q[k-1].trq[FRAC_BITS-1:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        it_q[k] <= it_d[k];
      end
    end
  end

  // back stages: sign of t, thresholds, classification, interior point
  pay_t                   pp_q [4];
  flags_t                 fl1_q, fl2_q;
  logic [TW-1:0]          mag1;
  logic signed [TW-1:0]   t1_q, t2_q, ntr2_q, ptr2_q, lo2_q, hi2_q, trw;
  logic [FRAC_BITS:0]     tr1_q, tm3_q;
  hit_kind_e              kind3_d, kind3_q, kind4_q;
  coord_t                 lp3_q, lp4_q;
  logic signed [PW-1:0]   pr4_q [3];
  logic signed [CoordW+2:0] ips [3];
  coord_t                 ipt [3];
  logic [3*CoordW-1:0]    hit, sec;

  assign mag1 = it_q[LD].ovf ? CapT : TW'(it_q[LD].q);
  assign trw  = $signed(TW'(tr1_q));

  always_comb begin
    if (!fl2_q.nonpar) begin
      kind3_d = fl2_q.on ? KIND_COINCIDENT : KIND_NONE;
    end else if (fl2_q.err) begin
      kind3_d = KIND_DEGENERATE;
    end else if (t2_q < ntr2_q) begin
      kind3_d = KIND_NONE;
    end else if (t2_q < ptr2_q) begin
      kind3_d = KIND_START;
    end else if (t2_q < lo2_q) begin
      kind3_d = KIND_INTERIOR;
    end else if (t2_q < hi2_q) begin
      kind3_d = KIND_END;
    end else begin
      kind3_d = KIND_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_q[0] <= it_q[LD].pay;
      fl1_q   <= it_q[LD].fl;
      t1_q    <= it_q[LD].neg ? -$signed(mag1) : $signed(mag1);
      tr1_q   <= (it_q[LD].root == '0) ? '0 : it_q[LD].trq;
      pp_q[1] <= pp_q[0];
      fl2_q   <= fl1_q;
      t2_q    <= t1_q;
      ntr2_q  <= -trw;
      ptr2_q  <= trw;
      lo2_q   <= OneT - trw;
      hi2_q   <= OneT + trw;
      pp_q[2] <= pp_q[1];
      kind3_q <= kind3_d;
      lp3_q   <= (fl2_q.nonpar && !fl2_q.err) ? sat32(64'(t2_q)) : '0;
      tm3_q   <= t2_q[FRAC_BITS:0];
      pp_q[3] <= pp_q[2];
      kind4_q <= kind3_q;
      lp4_q   <= lp3_q;
      for (int i = 0; i < 3; i++) begin
        pr4_q[i] <= $signed({1'b0, tm3_q}) * $signed(pp_q[2].e[CoordW*i +: CoordW]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ips[i] = (CoordW+3)'($signed(pp_q[3].d[CoordW*i +: CoordW])) +
               (CoordW+3)'(pr4_q[i] >>> FRAC_BITS);
      ipt[i] = sat32(64'(ips[i]));
    end
    hit = '0;
    sec = '0;
    case (kind4_q) inside
      KIND_START, KIND_COINCIDENT: hit = pp_q[3].d;
      KIND_INTERIOR:               hit = {ipt[2], ipt[1], ipt[0]};
      KIND_END:                    hit = pp_q[3].p;
      default: ;
    endcase
    if (kind4_q == KIND_COINCIDENT) begin
      sec = pp_q[3].p;
    end
    res = {{(OutW-OutBits){1'b0}}, sec, hit, lp4_q, kind4_q};
  end

endmodule

`default_nettype wire
